// File: rtl/core/hcm_pkg.sv
// Shared types, register codes and arithmetic helpers of the 3x3 mod-32 Hill cipher unit.
package hcm_pkg;

   localparam int SymW     = 5;
   localparam int RowW     = 3 * SymW;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = RowW;

   typedef logic [SymW-1:0] sym_type;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] REG_KEY_ROW_ZERO = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_KEY_ROW_ONE  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_KEY_ROW_TWO  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_DIRECTION    = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_PAD_SYMBOL   = 3'd4;

   // register reset values: identity key, encode, pad with index 26
   localparam logic [RowW-1:0] RST_KEY_ROW_ZERO = 15'd1;
   localparam logic [RowW-1:0] RST_KEY_ROW_ONE  = 15'd32;
   localparam logic [RowW-1:0] RST_KEY_ROW_TWO  = 15'd1024;
   localparam logic            RST_DIRECTION    = 1'b0;
   localparam sym_type         RST_PAD_SYMBOL   = 5'd26;

   localparam logic [1:0] FILL_FULL = 2'd2;
   localparam logic [1:0] EMIT_LAST = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COF,
      ST_DET,
      ST_SCALE,
      ST_CALC,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       req_ready;
      logic       hold;
      logic       form_block;
      logic [1:0] fill;
      logic       cof_step;
      logic       det_step;
      logic       scale_step;
      logic       calc;
      logic       emit_load;
      logic       emit_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic req_last;
      logic direction;
      logic cfg_write;
      logic out_free;
   } status_type;

   // product of two symbols, kept mod 32
   function automatic sym_type mul_mod(input sym_type a, input sym_type b);
      logic [2*SymW-1:0] p;
      p = a * b;
      return p[SymW-1:0];
   endfunction

   // multiplicative inverse mod 32 of an odd value; even values give zero
   function automatic sym_type inv_mod(input sym_type d);
      sym_type r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd11;
         5'd5:    r = 5'd13;
         5'd7:    r = 5'd23;
         5'd9:    r = 5'd25;
         5'd11:   r = 5'd3;
         5'd13:   r = 5'd5;
         5'd15:   r = 5'd15;
         5'd17:   r = 5'd17;
         5'd19:   r = 5'd27;
         5'd21:   r = 5'd29;
         5'd23:   r = 5'd7;
         5'd25:   r = 5'd9;
         5'd27:   r = 5'd19;
         5'd29:   r = 5'd21;
         5'd31:   r = 5'd31;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/hcm_req_if.sv
// Input item channel: one symbol index and its end-of-message flag.
interface hcm_req_if;
   import hcm_pkg::*;

   logic    valid;
   logic    ready;
   sym_type symbol_in;
   logic    message_end;

   modport source (output valid, output symbol_in, output message_end, input ready);
   modport sink   (input valid, input symbol_in, input message_end, output ready);
endinterface

// File: rtl/core/hcm_rsp_if.sv
// Result item channel: one transformed symbol and its block flags.
interface hcm_rsp_if;
   import hcm_pkg::*;

   logic    valid;
   logic    ready;
   sym_type symbol_out;
   logic    block_last;
   logic    message_last;
   logic    key_error;

   modport source (output valid, output symbol_out, output block_last, output message_last,
                   output key_error, input ready);
   modport sink   (input valid, input symbol_out, input block_last, input message_last,
                   input key_error, output ready);
endinterface

// File: rtl/core/hcm_csr_if.sv
// Configuration write channel: register index and write data.
interface hcm_csr_if;
   import hcm_pkg::*;

   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/hcm_ctrl.sv
// Controller state machine: block gathering, inverse key sequencing and result emission.
module hcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  hcm_pkg::status_type status,
   output hcm_pkg::cmd_type    cmd
);
   import hcm_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] emit_cnt_ff, emit_cnt_in;
   logic       inv_ready_ff, inv_ready_in;

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 2'd0;
         emit_cnt_ff  <= 2'd0;
         inv_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         emit_cnt_ff  <= emit_cnt_in;
         inv_ready_ff <= inv_ready_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      emit_cnt_in    = emit_cnt_ff;
      inv_ready_in   = inv_ready_ff;
      cmd            = '0;
      cmd.fill       = fill_ff;
      cmd.emit_final = (emit_cnt_ff == EMIT_LAST);

      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               if (fill_ff != FILL_FULL && !status.req_last) begin
                  cmd.hold = 1'b1;
                  fill_in  = fill_ff + 2'd1;
               end else begin
                  cmd.form_block = 1'b1;
                  fill_in        = 2'd0;
                  if (status.direction && !inv_ready_ff) begin
                     state_in = ST_COF;
                  end else begin
                     state_in = ST_CALC;
                  end
               end
            end
         end
         ST_COF: begin
            cmd.cof_step = 1'b1;
            state_in     = ST_DET;
         end
         ST_DET: begin
            cmd.det_step = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_step = 1'b1;
            inv_ready_in   = 1'b1;
            state_in       = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc    = 1'b1;
            emit_cnt_in = 2'd0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (emit_cnt_ff == EMIT_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_cnt_in = emit_cnt_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // drop the inverse key after any register write
      if (status.cfg_write) begin
         inv_ready_in = 1'b0;
      end
   end

endmodule

// File: rtl/core/hcm_datapath.sv
// Datapath: configuration registers, block buffer, inverse key unit and vector-matrix product.
module hcm_datapath (
   input  logic              clock,
   input  logic              reset,
   hcm_req_if.sink           req_chan,
   hcm_rsp_if.source         rsp_chan,
   hcm_csr_if.sink           csr_chan,
   input  hcm_pkg::cmd_type  cmd,
   output hcm_pkg::status_type status
);
   import hcm_pkg::*;

   logic [RowW-1:0] key_row_ff [3];
   logic            dir_ff;
   sym_type         pad_ff;

   sym_type held_ff [2];
   sym_type vec_ff  [3];
   logic    last_ff;

   sym_type key_k    [3][3];
   sym_type cof_next [3][3];
   sym_type cof_ff   [3][3];
   sym_type inv_ff   [3][3];
   sym_type mat      [3][3];
   sym_type det;
   sym_type dinv_ff;
   logic    key_inv_ff;

   sym_type res_ff [3];
   sym_type res_in [3];
   logic    err_ff;
   logic    err_in;

   sym_type out_sym_ff;
   logic    out_blast_ff, out_mlast_ff, out_err_ff, out_valid_ff;
   logic    cfg_hit;

   // configuration writes, always ready
   assign csr_chan.ready = 1'b1;
   always_comb begin
      case (csr_chan.index)
         REG_KEY_ROW_ZERO, REG_KEY_ROW_ONE, REG_KEY_ROW_TWO,
         REG_DIRECTION, REG_PAD_SYMBOL: cfg_hit = 1'b1;
         default:                       cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_row_ff[0] <= RST_KEY_ROW_ZERO;
         key_row_ff[1] <= RST_KEY_ROW_ONE;
         key_row_ff[2] <= RST_KEY_ROW_TWO;
         dir_ff        <= RST_DIRECTION;
         pad_ff        <= RST_PAD_SYMBOL;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_KEY_ROW_ZERO: key_row_ff[0] <= csr_chan.data;
            REG_KEY_ROW_ONE:  key_row_ff[1] <= csr_chan.data;
            REG_KEY_ROW_TWO:  key_row_ff[2] <= csr_chan.data;
            REG_DIRECTION:    dir_ff        <= csr_chan.data[0];
            REG_PAD_SYMBOL:   pad_ff        <= csr_chan.data[SymW-1:0];
            default:          ;
         endcase
      end
   end

   // unpack key rows, column zero in the low bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            key_k[r][c] = key_row_ff[r][SymW*c +: SymW];
         end
      end
   end

   // gather symbols and form the padded block
   assign req_chan.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff[0] <= '0;
         held_ff[1] <= '0;
      end else if (cmd.hold) begin
         held_ff[cmd.fill[0]] <= req_chan.symbol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.form_block) begin
         last_ff <= req_chan.message_end;
         case (cmd.fill)
            2'd0: begin
               vec_ff[0] <= req_chan.symbol_in;
               vec_ff[1] <= pad_ff;
               vec_ff[2] <= pad_ff;
            end
            2'd1: begin
               vec_ff[0] <= held_ff[0];
               vec_ff[1] <= req_chan.symbol_in;
               vec_ff[2] <= pad_ff;
            end
            default: begin
               vec_ff[0] <= held_ff[0];
               vec_ff[1] <= held_ff[1];
               vec_ff[2] <= req_chan.symbol_in;
            end
         endcase
      end
   end

   // signed cofactors of all key entries, reduced mod 32
   for (genvar r = 0; r < 3; r++) begin : g_cof_row
      for (genvar c = 0; c < 3; c++) begin : g_cof_col
         localparam int R1 = (r + 1) % 3;
         localparam int R2 = (r + 2) % 3;
         localparam int C1 = (c + 1) % 3;
         localparam int C2 = (c + 2) % 3;
         assign cof_next[r][c] = mul_mod(key_k[R1][C1], key_k[R2][C2])
                               - mul_mod(key_k[R1][C2], key_k[R2][C1]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cof_step) begin
         cof_ff <= cof_next;
      end
   end

   // determinant along row zero and its inverse
   assign det = mul_mod(key_k[0][0], cof_ff[0][0])
              + mul_mod(key_k[0][1], cof_ff[0][1])
              + mul_mod(key_k[0][2], cof_ff[0][2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_inv_ff <= 1'b0;
      end else if (cmd.det_step) begin
         key_inv_ff <= det[0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.det_step) begin
         dinv_ff <= inv_mod(det);
      end
   end

   // inverse key: transposed cofactors scaled by the determinant inverse
   always_ff @(posedge clock) begin
      if (cmd.scale_step) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               inv_ff[i][j] <= mul_mod(cof_ff[j][i], dinv_ff);
            end
         end
      end
   end

   // row vector times selected matrix, all three columns
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mat[i][j] = dir_ff ? inv_ff[i][j] : key_k[i][j];
         end
      end
      err_in = dir_ff & ~key_inv_ff;
      for (int j = 0; j < 3; j++) begin
         res_in[j] = mul_mod(vec_ff[0], mat[0][j])
                   + mul_mod(vec_ff[1], mat[1][j])
                   + mul_mod(vec_ff[2], mat[2][j]);
         if (err_in) begin
            res_in[j] = '0;
         end
      end
   end

   // load results, then shift them toward the output register
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         res_ff <= res_in;
         err_ff <= err_in;
      end else if (cmd.emit_load) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
      end
   end

   // output register, freed when the receiver takes the item
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_sym_ff   <= res_ff[0];
         out_blast_ff <= cmd.emit_final;
         out_mlast_ff <= cmd.emit_final & last_ff;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.symbol_out   = out_sym_ff;
   assign rsp_chan.block_last   = out_blast_ff;
   assign rsp_chan.message_last = out_mlast_ff;
   assign rsp_chan.key_error    = out_err_ff;

   // status toward the controller
   assign status.req_valid = req_chan.valid;
   assign status.req_last  = req_chan.message_end;
   assign status.direction = dir_ff;
   assign status.cfg_write = csr_chan.valid & cfg_hit;
   assign status.out_free  = ~out_valid_ff | rsp_chan.ready;

endmodule

// File: rtl/core/hill_cipher_3x3_mod32_unit.sv
// Top level of the 3x3 mod-32 Hill cipher unit: controller plus datapath.
//
// req_chan takes one 5-bit symbol index per item, with message_end on the
// final symbol of a message. Symbols are gathered in blocks of three; a
// block closes on its third symbol or on message_end, padding missing
// positions with pad_symbol. Each closed block gives three items on
// rsp_chan, block_last on the third and message_last on the third of a
// block that ends the message.
// Symbols are taken in ST_IDLE; a closing symbol is followed by the
// vector-matrix product (ST_CALC) and by ST_EMIT, which sends the block's
// three items, and no new symbol is taken until the block is out. The
// first decode after a register write first forms the inverse
// key (cofactors, determinant, scaling). The first result passes through the
// block vector, result and output registers before it is valid on rsp_chan.
// A stalled receiver holds the output register; emission waits, and req_chan
// stays low on ready until the block is out. csr_chan is always ready.
// Reset (synchronous) restores the register defaults and empties the block.
module hill_cipher_3x3_mod32_unit (
   input logic       clock,
   input logic       reset,
   hcm_req_if.sink   req_chan,
   hcm_rsp_if.source rsp_chan,
   hcm_csr_if.sink   csr_chan
);
   import hcm_pkg::*;

   cmd_type    cmd;
   status_type status;

   hcm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   hcm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// File: verif/hcm_cipher_checker.sv
// Checker for the Hill cipher unit: mirrors the block in software and compares every result item.
module hcm_cipher_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  hcm_pkg::sym_type             req_symbol_in,
   input  logic                         req_message_end,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  hcm_pkg::sym_type             rsp_symbol_out,
   input  logic                         rsp_block_last,
   input  logic                         rsp_message_last,
   input  logic                         rsp_key_error,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [hcm_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [hcm_pkg::CsrDataW-1:0] csr_data,
   output int                           fail_count,
   output int                           pending_count,
   output int                           checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hcm_pkg::*;

   typedef struct packed {
      sym_type symbol;
      logic    block_last;
      logic    message_last;
      logic    key_error;
   } cipher_item_type;

   cipher_item_type awaited_q[$];

   // mirrored registers
   logic [RowW-1:0] key_row [3];
   logic            decode_mode;
   sym_type         pad_value;

   // mirrored block state
   sym_type    held [2];
   logic [1:0] fill;
   sym_type    inv_key [3][3];
   logic       inv_formed;
   logic       key_odd;

   function automatic sym_type key_at(input int r, input int c);
      return key_row[r][SymW*c +: SymW];
   endfunction

   // signed cofactor of (r,c), wrapped to 5 bits
   function automatic sym_type cofactor_mod(input int r, input int c);
      sym_type a, b, x, y;
      a = key_at((r + 1) % 3, (c + 1) % 3);
      b = key_at((r + 2) % 3, (c + 2) % 3);
      x = key_at((r + 1) % 3, (c + 2) % 3);
      y = key_at((r + 2) % 3, (c + 1) % 3);
      return sym_type'(a * b - x * y);
   endfunction

   // build adj(K) * det^-1, all mod 32
   task automatic form_inverse_key();
      sym_type det, det_inv;
      det = '0;
      for (int j = 0; j < 3; j++)
         det = sym_type'(det + key_at(0, j) * cofactor_mod(0, j));
      key_odd = det[0];
      det_inv = '0;
      if (key_odd) begin
         for (int t = 1; t < 32; t += 2)
            if (sym_type'(t * det) == sym_type'(1)) det_inv = sym_type'(t);
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            inv_key[i][j] = sym_type'(cofactor_mod(j, i) * det_inv);
      inv_formed = 1'b1;
   endtask

   task automatic apply_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      case (idx)
         REG_KEY_ROW_ZERO: key_row[0] = data;
         REG_KEY_ROW_ONE:  key_row[1] = data;
         REG_KEY_ROW_TWO:  key_row[2] = data;
         REG_DIRECTION:    decode_mode = data[0];
         REG_PAD_SYMBOL:   pad_value = data[SymW-1:0];
         default:          return;
      endcase
      inv_formed = 1'b0;
   endtask

   // gather one symbol; a closed block queues its three expected items
   task automatic take_symbol(input sym_type sym, input logic last);
      sym_type         vec [3];
      sym_type         mat [3][3];
      sym_type         acc;
      logic            bad;
      cipher_item_type exp_item;
      if (fill < FILL_FULL && !last) begin
         held[fill[0]] = sym;
         fill = fill + 2'd1;
         return;
      end
      case (fill)
         2'd0:    begin vec[0] = sym;     vec[1] = pad_value; vec[2] = pad_value; end
         2'd1:    begin vec[0] = held[0]; vec[1] = sym;       vec[2] = pad_value; end
         default: begin vec[0] = held[0]; vec[1] = held[1];   vec[2] = sym;       end
      endcase
      fill = 2'd0;
      bad = 1'b0;
      if (decode_mode) begin
         if (!inv_formed) form_inverse_key();
         mat = inv_key;
         bad = !key_odd;
      end else begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) mat[r][c] = key_at(r, c);
      end
      for (int j = 0; j < 3; j++) begin
         acc = '0;
         for (int i = 0; i < 3; i++) acc = sym_type'(acc + vec[i] * mat[i][j]);
         exp_item.symbol       = bad ? sym_type'(0) : acc;
         exp_item.block_last   = (j == 2);
         exp_item.message_last = (j == 2) && last;
         exp_item.key_error    = bad;
         awaited_q = {awaited_q, exp_item};
      end
   endtask

   // follow all three channels at each edge
   always @(posedge clock) begin
      cipher_item_type want;
      if (reset) begin
         key_row[0]    = RST_KEY_ROW_ZERO;
         key_row[1]    = RST_KEY_ROW_ONE;
         key_row[2]    = RST_KEY_ROW_TWO;
         decode_mode   = RST_DIRECTION;
         pad_value     = RST_PAD_SYMBOL;
         held[0]       = '0;
         held[1]       = '0;
         fill          = 2'd0;
         inv_formed    = 1'b0;
         key_odd       = 1'b0;
         fail_count    = 0;
         checked_count = 0;
         awaited_q.delete();
      end else begin
         if (csr_valid && csr_ready) apply_write(csr_index, csr_data);
         if (req_valid && req_ready) take_symbol(req_symbol_in, req_message_end);
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               $error("result item with no block pending: symbol_out %0d", rsp_symbol_out);
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               checked_count++;
               if (rsp_symbol_out !== want.symbol) begin
                  $error("symbol_out: expected %0d, actual %0d", want.symbol, rsp_symbol_out);
                  fail_count++;
               end
               if (rsp_block_last !== want.block_last) begin
                  $error("block_last: expected %0b, actual %0b", want.block_last,
                         rsp_block_last);
                  fail_count++;
               end
               if (rsp_message_last !== want.message_last) begin
                  $error("message_last: expected %0b, actual %0b", want.message_last,
                         rsp_message_last);
                  fail_count++;
               end
               if (rsp_key_error !== want.key_error) begin
                  $error("key_error: expected %0b, actual %0b", want.key_error, rsp_key_error);
                  fail_count++;
               end
            end
         end
      end
      pending_count = awaited_q.size();
   end

endmodule

// File: verif/tb_hill_cipher_3x3_mod32_unit.sv
// Testbench top for the Hill cipher unit: clock, reset, stimulus, output stalls and verdict.
module tb_hill_cipher_3x3_mod32_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import hcm_pkg::*;

   localparam int RANDOM_PHASES  = 8;
   localparam int PRESSURE_PHASE = 3;
   localparam int PHASE_SYMBOLS  = 41;
   localparam int HOLD_CYCLES    = 90;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CsrIdxW-1:0] REG_FIRST_UNUSED = REG_PAD_SYMBOL + 1'b1;
   localparam logic [CsrIdxW-1:0] REG_LAST_UNUSED  = '1;
   localparam logic [CsrIdxW-1:0] KEY_REGS [3] =
      '{REG_KEY_ROW_ZERO, REG_KEY_ROW_ONE, REG_KEY_ROW_TWO};

   logic clock;
   logic reset;

   hcm_req_if req_chan ();
   hcm_rsp_if rsp_chan ();
   hcm_csr_if csr_chan ();

   int fail_count, pending_count, checked_count;
   int idle_pct_req, idle_pct_rsp;
   bit hold_output;
   int symbols_sent, messages_sent, csr_writes;
   int idle_cycles;

   hill_cipher_3x3_mod32_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   hcm_cipher_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_symbol_in    (req_chan.symbol_in),
      .req_message_end  (req_chan.message_end),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_symbol_out   (rsp_chan.symbol_out),
      .rsp_block_last   (rsp_chan.block_last),
      .rsp_message_last (rsp_chan.message_last),
      .rsp_key_error    (rsp_chan.key_error),
      .csr_valid        (csr_chan.valid),
      .csr_ready        (csr_chan.ready),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_hill_cipher_3x3_mod32_unit: FAIL");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_output) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else if (idle_pct_rsp != 0 && $urandom_range(0, 99) < idle_pct_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // offer one symbol, maybe after an idle burst, and hold until accepted
   task automatic send_symbol(input sym_type sym, input logic last);
      if (idle_pct_req != 0 && $urandom_range(0, 99) < idle_pct_req) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.symbol_in   <= sym;
      req_chan.message_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      symbols_sent++;
   endtask

   task automatic send_message(input sym_type syms[$]);
      foreach (syms[n]) send_symbol(syms[n], n == syms.size() - 1);
      messages_sent++;
   endtask

   task automatic send_random_message(input int max_len);
      int len;
      len = $urandom_range(1, max_len);
      for (int n = 0; n < len; n++)
         send_symbol(sym_type'($urandom_range(0, 31)), n == len - 1);
      messages_sent++;
   endtask

   // keep valid high across back-to-back writes; drop it with csr_release
   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_writes++;
   endtask

   task automatic csr_release();
      csr_chan.valid <= 1'b0;
   endtask

   // drain all expected items, then let any held work settle
   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      sym_type         msg[$];
      logic [RowW-1:0] rows [3];
      int              mode, phase_end;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.symbol_in   <= '0;
      req_chan.message_end <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= '0;
      csr_chan.data        <= '0;
      idle_pct_req = 20;
      idle_pct_rsp = 20;
      hold_output  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default identity key: single symbol, one pad, full block with end, multi-block
      msg = '{5'd0};                     send_message(msg);
      msg = '{5'd31, 5'd17};             send_message(msg);
      msg = '{5'd5, 5'd9, 5'd31};        send_message(msg);
      msg = '{5'd1, 5'd2, 5'd3, 5'd4};   send_message(msg);
      finish_phase();

      // invertible key with negative cofactors, pad at zero, encode
      csr_write(REG_KEY_ROW_ZERO, {5'd1, 5'd24, 5'd6});
      csr_write(REG_KEY_ROW_ONE,  {5'd10, 5'd16, 5'd13});
      csr_write(REG_KEY_ROW_TWO,  {5'd15, 5'd17, 5'd20});
      csr_write(REG_DIRECTION,    CsrDataW'(0));
      csr_write(REG_PAD_SYMBOL,   CsrDataW'(0));
      csr_release();
      msg = '{5'd31, 5'd31, 5'd31, 5'd0}; send_message(msg);
      finish_phase();

      // same key, decode
      csr_write(REG_DIRECTION, CsrDataW'(1));
      csr_release();
      msg = '{5'd31, 5'd0, 5'd16};        send_message(msg);
      finish_phase();

      // even determinant: decode flags key_error, encode does not; pad at top
      csr_write(REG_KEY_ROW_ZERO, CsrDataW'(2));
      csr_write(REG_KEY_ROW_ONE,  RST_KEY_ROW_ONE);
      csr_write(REG_KEY_ROW_TWO,  RST_KEY_ROW_TWO);
      csr_write(REG_PAD_SYMBOL,   CsrDataW'(31));
      csr_release();
      msg = '{5'd7};                      send_message(msg);
      finish_phase();
      csr_write(REG_DIRECTION, CsrDataW'(0));
      csr_release();
      msg = '{5'd31, 5'd30};              send_message(msg);
      finish_phase();

      // all-ones key, decode, and writes to unused indexes that must be ignored
      for (int r = 0; r < 3; r++) csr_write(KEY_REGS[r], '1);
      csr_write(REG_DIRECTION, '1);
      csr_write(REG_FIRST_UNUSED, '1);
      csr_write(REG_LAST_UNUSED, '0);
      csr_release();
      msg = '{5'd3, 5'd4, 5'd5};          send_message(msg);
      finish_phase();

      // random phases, each with a fresh configuration
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = $urandom_range(0, 3);
         for (int r = 0; r < 3; r++) begin
            rows[r] = RowW'($urandom_range(0, 32767));
            if (mode == 1 || mode == 2) begin
               // triangular with odd diagonal keeps the determinant odd
               rows[r][SymW*r] = 1'b1;
               for (int c = 0; c < 3; c++)
                  if ((mode == 1 && c > r) || (mode == 2 && c < r))
                     rows[r][SymW*c +: SymW] = '0;
            end else if (mode == 3) begin
               rows[r] = ph[0] ? '1 : '0;
            end
            csr_write(KEY_REGS[r], rows[r]);
         end
         if ($urandom_range(0, 3) != 0)
            csr_write(REG_DIRECTION, CsrDataW'($urandom_range(0, 32767)));
         if ($urandom_range(0, 3) != 0)
            csr_write(REG_PAD_SYMBOL, CsrDataW'($urandom_range(0, 32767)));
         if ($urandom_range(0, 3) == 0)
            csr_write(CsrIdxW'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      CsrDataW'($urandom_range(0, 32767)));
         csr_release();

         // idle pattern per phase; none in the last stretch
         if (ph >= RANDOM_PHASES - 2) begin
            idle_pct_req = 0;
            idle_pct_rsp = 0;
         end else begin
            idle_pct_req = 25 * $urandom_range(0, 2);
            idle_pct_rsp = 25 * $urandom_range(0, 2);
         end
         if (ph == PRESSURE_PHASE) begin
            idle_pct_req = 0;
            hold_output  = 1'b1;
         end

         phase_end = symbols_sent + PHASE_SYMBOLS;
         while (symbols_sent < phase_end) send_random_message(ph[0] ? 12 : 6);
         finish_phase();
      end

      $display("Run covered %0d symbols in %0d messages and %0d register writes;",
               symbols_sent, messages_sent, csr_writes);
      $display("%0d result items checked over encode, decode and even-determinant keys.",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_hill_cipher_3x3_mod32_unit: PASS");
      end else begin
         $display("tb_hill_cipher_3x3_mod32_unit: FAIL");
      end
      $finish;
   end

endmodule
